### sv/fpcam_pkg.sv
// Package for the fly camera pose keeper: codes, states, fixed-point constants
// and the arctangent table of the shared CORDIC rotator.
// No dependencies.
`default_nettype none

package fpcam_pkg;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 208;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [18:0] DEG_FULL    = 19'sd92160;
    localparam logic signed [18:0] DEG_HALF    = 19'sd46080;
    localparam logic signed [18:0] DEG_QUARTER = 19'sd23040;
    localparam logic signed [18:0] DEG_3QUART  = 19'sd69120;
    localparam logic signed [18:0] PITCH_LIM   = 19'sd22784;
    localparam logic signed [18:0] PITCH_MAX   = 19'sd32767;
    localparam logic signed [18:0] PITCH_MIN   = -19'sd32768;
    localparam logic signed [18:0] FOV_MIN     = 19'sd256;
    localparam logic signed [18:0] FOV_MAX     = 19'sd11520;
    localparam logic [13:0]        FOV_RESET   = 14'd11520;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [15:0] UNIT_POS    = 16'sd16384;
    localparam logic signed [15:0] UNIT_NEG    = -16'sd16384;

    localparam logic [15:0] SPEED_RESET = 16'd768;
    localparam logic [15:0] SENS_RESET  = 16'd16384;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SENS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UP_X  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UP_Y  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UP_Z  = 3'd4;

    typedef enum logic [1:0] {
        FUNC_SCROLL,
        FUNC_MOUSE,
        FUNC_KEY,
        FUNC_NONE
    } func_t;

    typedef enum logic [1:0] {
        DIR_FWD,
        DIR_BACK,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_M_DX,
        ST_M_DY,
        ST_M_PITCH,
        ST_C_INIT,
        ST_C_ITER,
        ST_C_DONE,
        ST_F_MUL,
        ST_F_STORE,
        ST_N_SQ,
        ST_N_ACC,
        ST_N_SQRT,
        ST_N_DIV_INIT,
        ST_N_DIV,
        ST_N_DIV_END,
        ST_X_M1,
        ST_X_M2,
        ST_X_SUB,
        ST_K_VEL,
        ST_K_VSTORE,
        ST_K_MUL,
        ST_K_ADD,
        ST_DONE
    } state_t;

    function automatic logic [21:0] atan_lut(input logic [3:0] i);
        logic [21:0] r;
        begin
            case (i)
                4'd0:    r = 22'd2949120;
                4'd1:    r = 22'd1740967;
                4'd2:    r = 22'd919879;
                4'd3:    r = 22'd466945;
                4'd4:    r = 22'd234379;
                4'd5:    r = 22'd117304;
                4'd6:    r = 22'd58666;
                4'd7:    r = 22'd29335;
                4'd8:    r = 22'd14668;
                4'd9:    r = 22'd7334;
                4'd10:   r = 22'd3667;
                4'd11:   r = 22'd1833;
                4'd12:   r = 22'd917;
                4'd13:   r = 22'd458;
                4'd14:   r = 22'd229;
                default: r = 22'd115;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [32:0] sext33(input logic signed [15:0] v);
        return {{17{v[15]}}, v};
    endfunction

    // round a CORDIC output to Q2.14 and clamp to the unit range
    function automatic logic signed [15:0] cordic_out(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + 34'sd32768) >>> 16;
            if (r > 34'sd16384)
                r = 34'sd16384;
            else if (r < -34'sd16384)
                r = -34'sd16384;
            return r[15:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/first_person_camera_pose.sv
// Fly camera pose keeper: position, yaw, pitch, field of view and front/right/up
// vectors, rebuilt by one shared multiplier, CORDIC, root and divide sequencer.
// Depends on fpcam_pkg.
// Work per item: a mouse move uses two 16-step CORDIC runs, three normalizations
// of 32 root steps plus three 15-step divides each, and two cross products.
// One item at a time; the next item is taken once the result sits in the
// output register.
// Reset: origin, yaw and pitch zero, 45 degree view, front +z.
`default_nettype none

module first_person_camera_pose (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // offset_x, offset_y, constrain_pitch, direction, delta_time, zero pad
    input  logic [fpcam_pkg::S_TDATA_W-1:0]      s_tdata,
    // func
    input  logic [fpcam_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pos_x, pos_y, pos_z, front_x..z, cam_up_x..z, view_angle, zero pad
    output logic [fpcam_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fpcam_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fpcam_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import fpcam_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]        speed_reg, speed_next;
    logic [15:0]        sens_reg, sens_next;
    logic signed [15:0] wup_reg [3];
    logic signed [15:0] wup_next [3];

    logic signed [15:0] ox_reg, ox_next;
    logic signed [15:0] oy_reg, oy_next;
    logic               cpitch_reg, cpitch_next;
    logic [1:0]         dir_reg, dir_next;
    logic [15:0]        dt_reg, dt_next;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic [16:0]        yaw_reg, yaw_next;
    logic signed [15:0] pitch_reg, pitch_next;
    logic [13:0]        fov_reg, fov_next;
    logic signed [15:0] front_reg [3];
    logic signed [15:0] front_next [3];
    logic signed [15:0] right_reg [3];
    logic signed [15:0] right_next [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] up_next [3];

    logic signed [65:0] prod_reg, prod_next;
    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] t_reg [3];
    logic signed [31:0] t_next [3];
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        sq_v_reg, sq_v_next;
    logic [63:0]        sq_r_reg, sq_r_next;
    logic [47:0]        rem_reg, rem_next;
    logic [47:0]        dsh_reg, dsh_next;
    logic [14:0]        q_reg, q_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [25:0] cz_reg, cz_next;
    logic               cneg_reg, cneg_next;
    logic               csel_reg, csel_next;
    logic signed [15:0] sy_reg, sy_next;
    logic signed [15:0] cyw_reg, cyw_next;
    logic signed [15:0] sp_reg, sp_next;
    logic signed [15:0] cp_reg, cp_next;
    logic [31:0]        vel_reg, vel_next;
    logic [4:0]         it_reg, it_next;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         nsel_reg, nsel_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic signed [65:0] prod_r16;
    logic signed [17:0] dxy;
    logic signed [18:0] ysum, ywrap;
    logic signed [18:0] psum, pclamp;
    logic signed [18:0] psx;
    logic signed [18:0] c_ang, c_red;
    logic               c_neg;
    logic signed [26:0] c_zi;
    logic signed [33:0] cxs, cys;
    logic signed [25:0] atan_z;
    logic signed [15:0] c_xo, c_yo, c_cos, c_sin;
    logic [63:0]        sq_bit, sq_rb;
    logic signed [31:0] t_sel;
    logic [31:0]        t_mag;
    logic [31:0]        len;
    logic [14:0]        q_clamp;
    logic signed [15:0] n_val;
    logic [1:0]         i1, i2;
    logic signed [15:0] xa [3];
    logic signed [15:0] xb [3];
    logic signed [15:0] kv;
    logic               k_sub;
    logic signed [65:0] k_dw;
    logic signed [33:0] k_p;
    logic signed [31:0] k_sat;
    logic signed [18:0] f_sum;
    logic [13:0]        f_clamp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign prod_next = mul_a * mul_b;

    // angle update
    assign prod_r16 = (prod_reg + 66'sd32768) >>> 16;
    assign dxy      = prod_r16[17:0];
    assign ysum     = $signed({2'b00, yaw_reg}) + $signed({dxy[17], dxy});
    assign psum     = $signed({{3{pitch_reg[15]}}, pitch_reg}) + $signed({dxy[17], dxy});
    assign psx      = $signed({{3{pitch_reg[15]}}, pitch_reg});

    always_comb
    begin
        if (ysum < 19'sd0)
            ywrap = ysum + DEG_FULL;
        else if (ysum >= DEG_FULL)
            ywrap = ysum - DEG_FULL;
        else
            ywrap = ysum;
        pclamp = psum;
        if (cpitch_reg)
        begin
            if (pclamp > PITCH_LIM)
                pclamp = PITCH_LIM;
            else if (pclamp < -PITCH_LIM)
                pclamp = -PITCH_LIM;
        end
        if (pclamp > PITCH_MAX)
            pclamp = PITCH_MAX;
        else if (pclamp < PITCH_MIN)
            pclamp = PITCH_MIN;
    end

    // CORDIC range reduction and step
    always_comb
    begin
        if (csel_reg)
            c_ang = pitch_reg[15] ? psx + DEG_FULL : psx;
        else
            c_ang = $signed({2'b00, yaw_reg});
        c_neg = 1'b0;
        c_red = c_ang;
        if (c_ang > DEG_QUARTER && c_ang < DEG_3QUART)
        begin
            c_red = c_ang - DEG_HALF;
            c_neg = 1'b1;
        end
        else if (c_ang >= DEG_3QUART)
        begin
            c_red = c_ang - DEG_FULL;
        end
    end

    assign c_zi   = {c_red, 8'h00};
    assign cxs    = cx_reg >>> it_reg[3:0];
    assign cys    = cy_reg >>> it_reg[3:0];
    assign atan_z = $signed({4'b0000, atan_lut(it_reg[3:0])});
    assign c_xo   = cordic_out(cx_reg);
    assign c_yo   = cordic_out(cy_reg);
    assign c_cos  = cneg_reg ? -c_xo : c_xo;
    assign c_sin  = cneg_reg ? -c_yo : c_yo;

    // root and divide
    assign sq_bit  = 64'd1 << {it_reg, 1'b0};
    assign sq_rb   = sq_r_reg + sq_bit;
    assign t_sel   = t_reg[idx_reg];
    assign t_mag   = t_sel[31] ? 32'(-t_sel) : 32'(t_sel);
    assign len     = sq_r_reg[31:0];
    assign q_clamp = (q_reg > 15'd16384) ? 15'd16384 : q_reg;
    assign n_val   = t_sel[31] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

    // cross product operands
    assign i1 = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
    assign i2 = (idx_reg == 2'd0) ? 2'd2 : idx_reg - 2'd1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xa[i] = (nsel_reg == 2'd1) ? front_reg[i] : right_reg[i];
            xb[i] = (nsel_reg == 2'd1) ? wup_reg[i] : front_reg[i];
        end
    end

    // key move
    assign kv    = (dir_reg == DIR_FWD || dir_reg == DIR_BACK) ?
                   front_reg[idx_reg] : right_reg[idx_reg];
    assign k_sub = (dir_reg == DIR_BACK || dir_reg == DIR_LEFT);
    assign k_dw  = (prod_reg + 66'sd2097152) >>> 22;
    assign k_p   = k_sub ? $signed({{2{pos_reg[idx_reg][31]}}, pos_reg[idx_reg]}) - k_dw[33:0]
                         : $signed({{2{pos_reg[idx_reg][31]}}, pos_reg[idx_reg]}) + k_dw[33:0];

    always_comb
    begin
        if (k_p > 34'sd2147483647)
            k_sat = 32'sh7FFFFFFF;
        else if (k_p < -34'sd2147483648)
            k_sat = 32'sh80000000;
        else
            k_sat = k_p[31:0];
    end

    // scroll
    assign f_sum = $signed({5'b00000, fov_reg}) - $signed({{3{oy_reg[15]}}, oy_reg});

    always_comb
    begin
        if (f_sum < FOV_MIN)
            f_clamp = FOV_MIN[13:0];
        else if (f_sum > FOV_MAX)
            f_clamp = FOV_MAX[13:0];
        else
            f_clamp = f_sum[13:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        speed_next    = speed_reg;
        sens_next     = sens_reg;
        wup_next      = wup_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        cpitch_next   = cpitch_reg;
        dir_next      = dir_reg;
        dt_next       = dt_reg;
        pos_next      = pos_reg;
        yaw_next      = yaw_reg;
        pitch_next    = pitch_reg;
        fov_next      = fov_reg;
        front_next    = front_reg;
        right_next    = right_reg;
        up_next       = up_reg;
        t_next        = t_reg;
        sum_next      = sum_reg;
        sq_v_next     = sq_v_reg;
        sq_r_next     = sq_r_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        cneg_next     = cneg_reg;
        csel_next     = csel_reg;
        sy_next       = sy_reg;
        cyw_next      = cyw_reg;
        sp_next       = sp_reg;
        cp_next       = cp_reg;
        vel_next      = vel_reg;
        it_next       = it_reg;
        idx_next      = idx_reg;
        nsel_next     = nsel_reg;
        mul_a         = '0;
        mul_b         = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_SPEED: speed_next = cfg_data;
                CFG_SENS:  sens_next = cfg_data;
                CFG_UP_X:  wup_next[0] = cfg_data;
                CFG_UP_Y:  wup_next[1] = cfg_data;
                CFG_UP_Z:  wup_next[2] = cfg_data;
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ox_next     = s_tdata[15:0];
                    oy_next     = s_tdata[31:16];
                    cpitch_next = s_tdata[32];
                    dir_next    = s_tdata[34:33];
                    dt_next     = s_tdata[50:35];
                    case (func_t'(s_tuser))
                        FUNC_SCROLL: state_next = ST_SCROLL;
                        FUNC_MOUSE:  state_next = ST_M_DX;
                        FUNC_KEY:    state_next = ST_K_VEL;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCROLL:
            begin
                fov_next   = f_clamp;
                state_next = ST_DONE;
            end
            ST_M_DX:
            begin
                mul_a      = sext33(ox_reg);
                mul_b      = {17'd0, sens_reg};
                state_next = ST_M_DY;
            end
            ST_M_DY:
            begin
                yaw_next   = ywrap[16:0];
                mul_a      = sext33(oy_reg);
                mul_b      = {17'd0, sens_reg};
                state_next = ST_M_PITCH;
            end
            ST_M_PITCH:
            begin
                pitch_next = pclamp[15:0];
                csel_next  = 1'b0;
                state_next = ST_C_INIT;
            end
            ST_C_INIT:
            begin
                cx_next    = CORDIC_K;
                cy_next    = '0;
                cz_next    = c_zi[25:0];
                cneg_next  = c_neg;
                it_next    = '0;
                state_next = ST_C_ITER;
            end
            ST_C_ITER:
            begin
                if (!cz_reg[25])
                begin
                    cx_next = cx_reg - cys;
                    cy_next = cy_reg + cxs;
                    cz_next = cz_reg - atan_z;
                end
                else
                begin
                    cx_next = cx_reg + cys;
                    cy_next = cy_reg - cxs;
                    cz_next = cz_reg + atan_z;
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd15)
                    state_next = ST_C_DONE;
            end
            ST_C_DONE:
            begin
                if (!csel_reg)
                begin
                    sy_next    = c_sin;
                    cyw_next   = c_cos;
                    csel_next  = 1'b1;
                    state_next = ST_C_INIT;
                end
                else
                begin
                    sp_next    = c_sin;
                    cp_next    = c_cos;
                    idx_next   = '0;
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        mul_a = sext33(sy_reg);
                        mul_b = sext33(cp_reg);
                    end
                    2'd1:
                    begin
                        mul_a = sext33(sp_reg);
                        mul_b = sext33(UNIT_POS);
                    end
                    default:
                    begin
                        mul_a = sext33(cyw_reg);
                        mul_b = sext33(cp_reg);
                    end
                endcase
                state_next = ST_F_STORE;
            end
            ST_F_STORE:
            begin
                t_next[idx_reg] = prod_reg[31:0];
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    nsel_next  = '0;
                    sum_next   = '0;
                    state_next = ST_N_SQ;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_F_MUL;
                end
            end
            ST_N_SQ:
            begin
                mul_a      = {t_sel[31], t_sel};
                mul_b      = {t_sel[31], t_sel};
                state_next = ST_N_ACC;
            end
            ST_N_ACC:
            begin
                sum_next = sum_reg + prod_reg[63:0];
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    sq_v_next  = sum_reg + prod_reg[63:0];
                    sq_r_next  = '0;
                    it_next    = 5'd31;
                    state_next = ST_N_SQRT;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_N_SQ;
                end
            end
            ST_N_SQRT:
            begin
                if (sq_v_reg >= sq_rb)
                begin
                    sq_v_next = sq_v_reg - sq_rb;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_r_next = sq_r_reg >> 1;
                end
                if (it_reg == 5'd0)
                begin
                    idx_next   = '0;
                    state_next = ST_N_DIV_INIT;
                end
                else
                begin
                    it_next = it_reg - 5'd1;
                end
            end
            ST_N_DIV_INIT:
            begin
                rem_next = {2'b00, t_mag[30:0], 15'd0} + {16'd0, len};
                dsh_next = {1'b0, len, 15'd0};
                q_next   = '0;
                it_next  = 5'd14;
                if (len == 32'd0)
                    state_next = ST_N_DIV_END;
                else
                    state_next = ST_N_DIV;
            end
            ST_N_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next            = rem_reg - dsh_reg;
                    q_next[it_reg[3:0]] = 1'b1;
                end
                dsh_next = dsh_reg >> 1;
                if (it_reg == 5'd0)
                    state_next = ST_N_DIV_END;
                else
                    it_next = it_reg - 5'd1;
            end
            ST_N_DIV_END:
            begin
                case (nsel_reg)
                    2'd0:    front_next[idx_reg] = n_val;
                    2'd1:    right_next[idx_reg] = n_val;
                    default: up_next[idx_reg] = n_val;
                endcase
                if (idx_reg == 2'd2)
                begin
                    idx_next = '0;
                    if (nsel_reg == 2'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        nsel_next  = nsel_reg + 2'd1;
                        state_next = ST_X_M1;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_N_DIV_INIT;
                end
            end
            ST_X_M1:
            begin
                mul_a      = sext33(xa[i1]);
                mul_b      = sext33(xb[i2]);
                state_next = ST_X_M2;
            end
            ST_X_M2:
            begin
                t_next[idx_reg] = prod_reg[31:0];
                mul_a           = sext33(xa[i2]);
                mul_b           = sext33(xb[i1]);
                state_next      = ST_X_SUB;
            end
            ST_X_SUB:
            begin
                t_next[idx_reg] = t_sel - prod_reg[31:0];
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_N_SQ;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_X_M1;
                end
            end
            ST_K_VEL:
            begin
                mul_a      = {17'd0, speed_reg};
                mul_b      = {17'd0, dt_reg};
                state_next = ST_K_VSTORE;
            end
            ST_K_VSTORE:
            begin
                vel_next   = prod_reg[31:0];
                idx_next   = '0;
                state_next = ST_K_MUL;
            end
            ST_K_MUL:
            begin
                mul_a      = sext33(kv);
                mul_b      = {1'b0, vel_reg};
                state_next = ST_K_ADD;
            end
            ST_K_ADD:
            begin
                pos_next[idx_reg] = k_sat;
                if (idx_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_K_MUL;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, fov_reg,
                                     up_reg[2], up_reg[1], up_reg[0],
                                     front_reg[2], front_reg[1], front_reg[0],
                                     pos_reg[2], pos_reg[1], pos_reg[0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            speed_reg    <= SPEED_RESET;
            sens_reg     <= SENS_RESET;
            wup_reg[0]   <= '0;
            wup_reg[1]   <= UNIT_POS;
            wup_reg[2]   <= '0;
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= '0;
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            fov_reg      <= FOV_RESET;
            front_reg[0] <= '0;
            front_reg[1] <= '0;
            front_reg[2] <= UNIT_POS;
            right_reg[0] <= UNIT_NEG;
            right_reg[1] <= '0;
            right_reg[2] <= '0;
            up_reg[0]    <= '0;
            up_reg[1]    <= UNIT_POS;
            up_reg[2]    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            speed_reg    <= speed_next;
            sens_reg     <= sens_next;
            wup_reg      <= wup_next;
            pos_reg      <= pos_next;
            yaw_reg      <= yaw_next;
            pitch_reg    <= pitch_next;
            fov_reg      <= fov_next;
            front_reg    <= front_next;
            right_reg    <= right_next;
            up_reg       <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        cpitch_reg  <= cpitch_next;
        dir_reg     <= dir_next;
        dt_reg      <= dt_next;
        prod_reg    <= prod_next;
        t_reg       <= t_next;
        sum_reg     <= sum_next;
        sq_v_reg    <= sq_v_next;
        sq_r_reg    <= sq_r_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        cneg_reg    <= cneg_next;
        csel_reg    <= csel_next;
        sy_reg      <= sy_next;
        cyw_reg     <= cyw_next;
        sp_reg      <= sp_next;
        cp_reg      <= cp_next;
        vel_reg     <= vel_next;
        it_reg      <= it_next;
        idx_reg     <= idx_next;
        nsel_reg    <= nsel_next;
    end

endmodule

`default_nettype wire

### sv/fpcam_chk.sv
// Port checker for the fly camera pose keeper, bound to the top level.
// Depends on fpcam_pkg.
`default_nettype none

module fpcam_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fpcam_pkg::M_TDATA_W-1:0]   m_tdata
);

    import fpcam_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // field of view stays within 1 to 45 degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[205:192] >= 14'd256) && (m_tdata[205:192] <= 14'd11520))
        else $error("view angle out of range");

endmodule

bind first_person_camera_pose fpcam_chk u_fpcam_chk (.*);

`default_nettype wire
